>>> rtl/core/cpbe_pkg.sv
// cpbe_pkg: shared types, codes, constants and CRC/header helpers for the
// controller-pak block engine. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cpbe_pkg;

    localparam int PAK_COUNT_DEF   = 4;
    localparam int PAK_BYTES_DEF   = 32768;
    localparam int BLOCK_BYTES     = 32;
    localparam int HDR_WORDS       = 34;
    localparam int BASE_W          = 14;

    localparam logic [7:0]  CRC_POLY  = 8'h85;
    localparam logic [15:0] ADDR_BAD  = 16'h8001;
    localparam logic [15:0] BLK_MASK  = 16'hFFE0;
    localparam logic [63:0] FILL_WORD = 64'h0003_0003_0003_0003;
    localparam logic [7:0]  ID_BYTE   = 8'h05;

    // request codes
    localparam logic [2:0] REQ_STATUS = 3'd0;
    localparam logic [2:0] REQ_PROBE  = 3'd1;
    localparam logic [2:0] REQ_READ   = 3'd2;
    localparam logic [2:0] REQ_WRITE  = 3'd3;
    localparam logic [2:0] REQ_FORMAT = 3'd4;

    // status codes
    localparam logic [7:0] ST_NONE       = 8'h00;
    localparam logic [7:0] ST_STATUS     = 8'h03;
    localparam logic [7:0] ST_STATUS_ABS = 8'h83;
    localparam logic [7:0] ST_PROBE      = 8'h04;
    localparam logic [7:0] ST_PROBE_ABS  = 8'h84;
    localparam logic [7:0] ST_READ       = 8'h21;
    localparam logic [7:0] ST_READ_ABS   = 8'hA1;
    localparam logic [7:0] ST_WRITE      = 8'h01;
    localparam logic [7:0] ST_WRITE_ABS  = 8'h81;

    // work kinds handed to the back end
    localparam logic [1:0] K_REPLY  = 2'd0;
    localparam logic [1:0] K_READ   = 2'd1;
    localparam logic [1:0] K_WRITE  = 2'd2;
    localparam logic [1:0] K_FORMAT = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        status;
        logic [63:0]       reply;
        logic              unch;
        logic              mem_en;
        logic [BASE_W-1:0] base;
        logic              first;
        logic              last;
        logic [63:0]       data;
    } t_cmd;

    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic [7:0] tap;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            tap = c[7] ? CRC_POLY : 8'h00;
            c   = {c[6:0], b[i]} ^ tap;
        end
        return c;
    endfunction

    function automatic logic [63:0] header_word(input logic [5:0] w);
        logic [63:0] v;
        case (w)
            6'd0:  v = 64'h8101_0203_0405_0607;
            6'd1:  v = 64'h0809_0a0b_0c0d_0e0f;
            6'd2:  v = 64'h1011_1213_1415_1617;
            6'd3:  v = 64'h1819_1a1b_1c1d_1e1f;
            6'd4, 6'd12, 6'd16, 6'd24:
                   v = 64'hffff_ffff_051a_5f13;
            6'd6, 6'd14, 6'd18, 6'd26:
                   v = 64'hffff_ffff_ffff_ffff;
            6'd7, 6'd15, 6'd19, 6'd27:
                   v = 64'hffff_01ff_6625_99cd;
            6'd32: v = 64'h0071_0003_0003_0003;
            6'd33: v = FILL_WORD;
            default: v = 64'h0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/cpbe_front.sv
// cpbe_front: accepts requests, classifies them into commands and queues
// them (two entries) for the back end. Depends on cpbe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpbe_front #(
    parameter int PAK_COUNT = cpbe_pkg::PAK_COUNT_DEF,
    parameter int PAK_BYTES = cpbe_pkg::PAK_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic [2:0]     i_req_type,
    input  wire logic [1:0]     i_channel,
    input  wire logic           i_tx_error,
    input  wire logic [15:0]    i_pak_address,
    input  wire logic [1:0]     i_chunk_index,
    input  wire logic [63:0]    i_write_word,
    input  wire logic [3:0]     i_present_mask,
    input  wire logic [3:0]     i_pak_mask,
    output cpbe_pkg::t_cmd      o_cmd,
    output logic                o_cmd_valid,
    input  wire logic           i_pop
);
    import cpbe_pkg::*;

    localparam int WPP = PAK_BYTES / 8;

    t_cmd              w_cmd;
    logic              w_present;
    logic              w_has_pak;
    logic              w_valid;
    logic [15:0]       w_blk;
    logic [BASE_W-1:0] w_base;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;

    always_comb begin
        w_present = i_present_mask[i_channel];
        w_has_pak = (int'(i_channel) < PAK_COUNT) && i_pak_mask[i_channel];
        w_blk     = i_pak_address & BLK_MASK;
        w_valid   = (i_pak_address != ADDR_BAD) && (w_blk <= 16'(PAK_BYTES - BLOCK_BYTES));
        w_base    = BASE_W'(32'(i_channel) * 32'(WPP)) + BASE_W'(w_blk[15:3]);

        w_cmd        = '0;
        w_cmd.mem_en = w_has_pak && w_valid;
        w_cmd.base   = w_base;
        w_cmd.first  = (i_chunk_index == 2'd0);
        w_cmd.last   = (i_chunk_index == 2'd3);
        w_cmd.data   = i_write_word;
        w_cmd.kind   = K_REPLY;
        case (i_req_type)
            REQ_STATUS: begin
                if (i_tx_error) begin
                    w_cmd.unch = 1'b1;
                end else if (w_present) begin
                    w_cmd.status = ST_STATUS;
                    w_cmd.reply  = {ID_BYTE, 8'h00, 7'b0, w_has_pak, 40'b0};
                end else begin
                    w_cmd.status = ST_STATUS_ABS;
                end
            end
            REQ_PROBE: begin
                w_cmd.status = w_present ? ST_PROBE : ST_PROBE_ABS;
            end
            REQ_READ: begin
                w_cmd.status = w_present ? ST_READ : ST_READ_ABS;
                w_cmd.kind   = w_present ? K_READ : K_REPLY;
            end
            REQ_WRITE: begin
                w_cmd.status = w_present ? ST_WRITE : ST_WRITE_ABS;
                w_cmd.kind   = w_present ? K_WRITE : K_REPLY;
                w_cmd.base   = w_base + BASE_W'(i_chunk_index);
            end
            REQ_FORMAT: begin
                w_cmd.kind = K_FORMAT;
            end
            default: begin
                w_cmd.unch = 1'b1;
            end
        endcase
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign w_push      = i_in_valid && o_in_ready;
    assign o_cmd       = r_q[r_rp];
    assign o_cmd_valid = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/cpbe_back.sv
// cpbe_back: executes queued commands against the pak memory, runs the
// byte-serial CRC and holds the result register. Depends on cpbe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpbe_back #(
    parameter int PAK_COUNT = cpbe_pkg::PAK_COUNT_DEF,
    parameter int PAK_BYTES = cpbe_pkg::PAK_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  cpbe_pkg::t_cmd      i_cmd,
    input  wire logic           i_cmd_valid,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic [7:0]          o_status_byte,
    output logic [63:0]         o_reply_word,
    output logic [7:0]          o_crc_byte,
    output logic                o_crc_valid,
    output logic                o_last_item,
    output logic                o_unchanged
);
    import cpbe_pkg::*;

    localparam int WPP    = PAK_BYTES / 8;
    localparam int DEPTH  = PAK_COUNT * WPP;
    localparam int MEM_AW = $clog2(DEPTH);
    localparam int FW_W   = $clog2(WPP);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_RDW  = 3'd2;
    localparam logic [2:0] S_CRC  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    localparam logic [2:0] S_FMT  = 3'd5;

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;

    logic [2:0]        r_state;
    t_cmd              r_cmd;
    logic [1:0]        r_k;
    logic [3:0]        r_bcnt;
    logic [63:0]       r_word;
    logic [63:0]       r_sh;
    logic [7:0]        r_crc;
    logic [7:0]        r_acc;
    logic [MEM_AW-1:0] r_fa;
    logic [FW_W-1:0]   r_fw;

    logic              w_we;
    logic [MEM_AW-1:0] w_waddr;
    logic [63:0]       w_wdata;
    logic [MEM_AW-1:0] w_raddr;
    logic              w_out_free;
    logic              w_flush;
    logic              w_cv;
    logic [7:0]        w_crc_next;

    assign w_out_free = !o_out_valid || i_out_ready;
    assign o_pop      = (r_state == S_IDLE) && i_cmd_valid;
    assign w_flush    = ((r_cmd.kind == K_READ) && (r_k == 2'd3)) ||
                        ((r_cmd.kind == K_WRITE) && r_cmd.last);
    assign w_cv       = w_flush;
    assign w_crc_next = crc_byte(r_crc, r_sh[63:56]);
    assign w_raddr    = MEM_AW'(r_cmd.base + BASE_W'(r_k));

    always_comb begin
        w_we    = 1'b0;
        w_waddr = MEM_AW'(i_cmd.base);
        w_wdata = i_cmd.data;
        if (r_state == S_FMT) begin
            w_we    = 1'b1;
            w_waddr = r_fa;
            w_wdata = (int'(r_fw) < HDR_WORDS) ? header_word(r_fw[5:0]) : FILL_WORD;
        end else if (o_pop && (i_cmd.kind == K_WRITE) && i_cmd.mem_en) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_k    <= 2'd0;
                r_bcnt <= 4'd0;
                r_fa   <= '0;
                r_fw   <= '0;
                if (o_pop) begin
                    r_cmd  <= i_cmd;
                    r_word <= i_cmd.data;
                    r_sh   <= i_cmd.data;
                    r_crc  <= (i_cmd.kind == K_WRITE && !i_cmd.first) ? r_acc : 8'h00;
                end
            end
            S_RDW: begin
                r_word <= r_cmd.mem_en ? r_rdata : 64'h0;
                r_sh   <= r_cmd.mem_en ? r_rdata : 64'h0;
                r_bcnt <= 4'd0;
            end
            S_CRC: begin
                r_crc  <= w_crc_next;
                r_sh   <= r_sh << 8;
                r_bcnt <= r_bcnt + 4'd1;
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_k <= r_k + 2'd1;
                end
            end
            S_FMT: begin
                r_fa <= r_fa + MEM_AW'(1);
                r_fw <= (r_fw == FW_W'(WPP - 1)) ? '0 : r_fw + FW_W'(1);
            end
            default: begin
            end
        endcase
    end

    // control and the write-CRC accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= 8'h00;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        case (i_cmd.kind)
                            K_READ:   r_state <= S_RD;
                            K_WRITE:  r_state <= S_CRC;
                            K_FORMAT: r_state <= S_FMT;
                            default:  r_state <= S_OUT;
                        endcase
                    end
                end
                S_RD:  r_state <= S_RDW;
                S_RDW: r_state <= S_CRC;
                S_CRC: begin
                    // the accumulator keeps the unflushed value
                    if (r_bcnt == 4'd7 && r_cmd.kind == K_WRITE) begin
                        r_acc <= w_crc_next;
                    end
                    if ((r_bcnt == 4'd7 && !w_flush) || r_bcnt == 4'd8) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= (r_cmd.kind == K_READ && r_k != 2'd3) ? S_RD : S_IDLE;
                    end
                end
                S_FMT: begin
                    if (r_fa == MEM_AW'(DEPTH - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            o_status_byte <= r_cmd.status;
            o_reply_word  <= (r_cmd.kind == K_REPLY) ? r_cmd.reply :
                             (r_cmd.kind == K_READ)  ? r_word : 64'h0;
            o_crc_byte    <= w_cv ? r_crc : 8'h00;
            o_crc_valid   <= w_cv;
            o_last_item   <= (r_cmd.kind != K_READ) || (r_k == 2'd3);
            o_unchanged   <= r_cmd.unch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/controller_pak_block_engine_core.sv
// A one-result request goes straight to the result register. A write chunk runs
// the CRC over its word, and the last chunk also flushes the CRC. A read returns
// four words, each read from memory and run through the CRC before it is output.
// Format writes one word a cycle over all PAK_COUNT*PAK_BYTES/8 words. One request
// runs in the back end at a time, and an output stall holds it.
// Sync active-low reset clears queue, sequencer, CRC, masks; pak memory undefined.
`timescale 1ns / 1ps
`default_nettype none
module controller_pak_block_engine_core #(
    parameter int PAK_COUNT = cpbe_pkg::PAK_COUNT_DEF,
    parameter int PAK_BYTES = cpbe_pkg::PAK_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [3:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [1:0]  i_channel,
    input  wire logic        i_tx_error,
    input  wire logic [15:0] i_pak_address,
    input  wire logic [1:0]  i_chunk_index,
    input  wire logic [63:0] i_write_word,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_status_byte,
    output logic [63:0]      o_reply_word,
    output logic [7:0]       o_crc_byte,
    output logic             o_crc_valid,
    output logic             o_last_item,
    output logic             o_unchanged
);
    import cpbe_pkg::*;

    localparam logic [1:0] CFG_PRESENT = 2'd0;
    localparam logic [1:0] CFG_PAK     = 2'd1;

    logic [3:0] r_present;
    logic [3:0] r_pak;
    t_cmd       w_cmd;
    logic       w_cmd_valid;
    logic       w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= 4'h0;
            r_pak     <= 4'h0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PRESENT: r_present <= i_cfg_data;
                CFG_PAK:     r_pak     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    cpbe_front #(.PAK_COUNT(PAK_COUNT), .PAK_BYTES(PAK_BYTES)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_channel      (i_channel),
        .i_tx_error     (i_tx_error),
        .i_pak_address  (i_pak_address),
        .i_chunk_index  (i_chunk_index),
        .i_write_word   (i_write_word),
        .i_present_mask (r_present),
        .i_pak_mask     (r_pak),
        .o_cmd          (w_cmd),
        .o_cmd_valid    (w_cmd_valid),
        .i_pop          (w_pop)
    );

    cpbe_back #(.PAK_COUNT(PAK_COUNT), .PAK_BYTES(PAK_BYTES)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cmd_valid   (w_cmd_valid),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status_byte (o_status_byte),
        .o_reply_word  (o_reply_word),
        .o_crc_byte    (o_crc_byte),
        .o_crc_valid   (o_crc_valid),
        .o_last_item   (o_last_item),
        .o_unchanged   (o_unchanged)
    );

`ifndef SYNTHESIS
    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_cmd_valid) else $error("pop from empty command queue");
    a_crc_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_crc_valid) |-> o_last_item)
        else $error("CRC reported on a non-final result");
    a_unch_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_unchanged) |-> (o_status_byte == 8'h00 &&
        o_reply_word == 64'h0 && !o_crc_valid))
        else $error("ignored request carries data");
`endif

endmodule
`default_nettype wire
